// ===== hw/rtl/tfpz_pkg.sv =====
// Shared constants for the two-finger pan and zoom dead-zone core.
`timescale 1ns / 1ps

package tfpz_pkg;

    // Default coordinate width in whole pixels
    localparam int COORD_BITS_DEF = 12;

    // Fraction bits of the fixed-point roots and ratios
    localparam int FRAC_BITS = 16;

    // Left shift of the pan component magnitude before the ratio divide
    localparam int DIV_SHIFT = 31;

    // Ratio quotient width; component/length ratio stays below three
    // times one in 16 fraction bits, so 18 bits hold every quotient
    localparam int RATIO_BITS = 18;

    // Dead-zone register
    localparam int DZ_BITS = 8;
    localparam logic [DZ_BITS-1:0] DEAD_ZONE_RESET = 8'd30;

endpackage

// ===== hw/rtl/tfpz_front.sv =====
// Front stages: midpoint sums, finger deltas, squares and squared lengths.
`timescale 1ns / 1ps

module tfpz_front #(
    parameter int C  = tfpz_pkg::COORD_BITS_DEF,
    parameter int VW = 2 * C + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          active,
    input  logic [C-1:0]                  start_a_x,
    input  logic [C-1:0]                  start_a_y,
    input  logic [C-1:0]                  start_b_x,
    input  logic [C-1:0]                  start_b_y,
    input  logic [C-1:0]                  now_a_x,
    input  logic [C-1:0]                  now_a_y,
    input  logic [C-1:0]                  now_b_x,
    input  logic [C-1:0]                  now_b_y,
    input  logic [2*tfpz_pkg::DZ_BITS-1:0] dead_zone_sq,
    output logic                          out_valid,
    output logic [VW-1:0]                 l2,
    output logic [VW-1:0]                 d1,
    output logic [VW-1:0]                 d2,
    output logic [C:0]                    mid_x,
    output logic [C:0]                    mid_y,
    output logic signed [C+1:0]           dhx,
    output logic signed [C+1:0]           dhy,
    output logic                          pan_on,
    output logic                          act
);

    // stage 1 combinational sums and differences
    logic [C:0]          mid_x_next, mid_y_next, now_x_sum, now_y_sum;
    logic signed [C+1:0] dhx_next, dhy_next;
    logic signed [C:0]   dx1_next, dy1_next, dx2_next, dy2_next;

    assign mid_x_next = {1'b0, start_a_x} + {1'b0, start_b_x};
    assign mid_y_next = {1'b0, start_a_y} + {1'b0, start_b_y};
    assign now_x_sum  = {1'b0, now_a_x} + {1'b0, now_b_x};
    assign now_y_sum  = {1'b0, now_a_y} + {1'b0, now_b_y};
    assign dhx_next   = $signed({1'b0, now_x_sum}) - $signed({1'b0, mid_x_next});
    assign dhy_next   = $signed({1'b0, now_y_sum}) - $signed({1'b0, mid_y_next});
    assign dx1_next   = $signed({1'b0, start_b_x}) - $signed({1'b0, start_a_x});
    assign dy1_next   = $signed({1'b0, start_b_y}) - $signed({1'b0, start_a_y});
    assign dx2_next   = $signed({1'b0, now_b_x}) - $signed({1'b0, now_a_x});
    assign dy2_next   = $signed({1'b0, now_b_y}) - $signed({1'b0, now_a_y});

    logic                v1_reg, v2_reg, v3_reg;
    logic                act1_reg, act2_reg, act3_reg;
    logic [C:0]          mx1_reg, my1_reg, mx2_reg, my2_reg, mx3_reg, my3_reg;
    logic signed [C+1:0] dhx1_reg, dhy1_reg, dhx2_reg, dhy2_reg, dhx3_reg, dhy3_reg;
    logic signed [C:0]   dx1_reg, dy1_reg, dx2_reg, dy2_reg;

    // stage 2 squares
    logic signed [2*C+3:0] phx, phy;
    logic signed [2*C+1:0] p1x, p1y, p2x, p2y;
    logic [2*C+1:0]        sqhx_reg, sqhy_reg;
    logic [2*C-1:0]        sq1x_reg, sq1y_reg, sq2x_reg, sq2y_reg;

    assign phx = dhx1_reg * dhx1_reg;
    assign phy = dhy1_reg * dhy1_reg;
    assign p1x = dx1_reg * dx1_reg;
    assign p1y = dy1_reg * dy1_reg;
    assign p2x = dx2_reg * dx2_reg;
    assign p2y = dy2_reg * dy2_reg;

    // stage 3 squared lengths and the pan threshold test
    logic [2*C+2:0] sumh;
    logic [2*C:0]   sum1, sum2;
    logic [VW-1:0]  l2_next;
    logic [VW-1:0]  l2_reg, d1_reg, d2_reg;
    logic           pan_on_reg;

    assign sumh    = {1'b0, sqhx_reg} + {1'b0, sqhy_reg};
    assign sum1    = {1'b0, sq1x_reg} + {1'b0, sq1y_reg};
    assign sum2    = {1'b0, sq2x_reg} + {1'b0, sq2y_reg};
    assign l2_next = VW'(sumh[2*C+2:2]);

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg   <= active;
            mx1_reg    <= mid_x_next;
            my1_reg    <= mid_y_next;
            dhx1_reg   <= dhx_next;
            dhy1_reg   <= dhy_next;
            dx1_reg    <= dx1_next;
            dy1_reg    <= dy1_next;
            dx2_reg    <= dx2_next;
            dy2_reg    <= dy2_next;

            act2_reg   <= act1_reg;
            mx2_reg    <= mx1_reg;
            my2_reg    <= my1_reg;
            dhx2_reg   <= dhx1_reg;
            dhy2_reg   <= dhy1_reg;
            sqhx_reg   <= phx[2*C+1:0];
            sqhy_reg   <= phy[2*C+1:0];
            sq1x_reg   <= p1x[2*C-1:0];
            sq1y_reg   <= p1y[2*C-1:0];
            sq2x_reg   <= p2x[2*C-1:0];
            sq2y_reg   <= p2y[2*C-1:0];

            act3_reg   <= act2_reg;
            mx3_reg    <= mx2_reg;
            my3_reg    <= my2_reg;
            dhx3_reg   <= dhx2_reg;
            dhy3_reg   <= dhy2_reg;
            l2_reg     <= l2_next;
            d1_reg     <= VW'(sum1);
            d2_reg     <= VW'(sum2);
            pan_on_reg <= (l2_next >= VW'(dead_zone_sq));
        end
    end

    assign out_valid = v3_reg;
    assign l2        = l2_reg;
    assign d1        = d1_reg;
    assign d2        = d2_reg;
    assign mid_x     = mx3_reg;
    assign mid_y     = my3_reg;
    assign dhx       = dhx3_reg;
    assign dhy       = dhy3_reg;
    assign pan_on    = pan_on_reg;
    assign act       = act3_reg;

endmodule

// ===== hw/rtl/tfpz_sqrt_pipe.sv =====
// Pipelined fixed-point square root, one result bit per stage, several lanes.
`timescale 1ns / 1ps

module tfpz_sqrt_pipe #(
    parameter int VW    = 26,
    parameter int FRAC  = tfpz_pkg::FRAC_BITS,
    parameter int LANES = 3,
    parameter int SW    = 8,
    parameter int RW    = VW / 2 + FRAC
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][VW-1:0]     in_v,
    input  logic [SW-1:0]                in_side,
    output logic                         out_valid,
    output logic [LANES-1:0][RW-1:0]     out_root,
    output logic [SW-1:0]                out_side
);

    localparam int N  = RW;
    localparam int MW = RW + 2;

    logic [LANES-1:0][VW-1:0] v_reg    [N];
    logic [LANES-1:0][RW-1:0] res_reg  [N];
    logic [LANES-1:0][MW-1:0] rem_reg  [N];
    logic [SW-1:0]            side_reg [N];
    logic                     valid_reg[N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [LANES-1:0][VW-1:0] v_src, v_next;
        logic [LANES-1:0][RW-1:0] res_src, res_next;
        logic [LANES-1:0][MW-1:0] rem_src, rem_next;
        logic [SW-1:0]            side_src;
        logic                     valid_src;

        if (k == 0)
        begin : g_first
            assign v_src     = in_v;
            assign res_src   = '0;
            assign rem_src   = '0;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign v_src     = v_reg[k-1];
            assign res_src   = res_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign side_src  = side_reg[k-1];
            assign valid_src = valid_reg[k-1];
        end

        // bring down the next bit pair and try the trial subtract
        always_comb
        begin
            logic [MW+1:0] acc;
            logic [MW+1:0] trial;
            for (int l = 0; l < LANES; l++)
            begin
                acc   = {rem_src[l], v_src[l][VW-1 -: 2]};
                trial = (MW + 2)'({res_src[l], 2'b01});
                v_next[l] = {v_src[l][VW-3:0], 2'b00};
                if (acc >= trial)
                begin
                    rem_next[l] = MW'(acc - trial);
                    res_next[l] = {res_src[l][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = acc[MW-1:0];
                    res_next[l] = {res_src[l][RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= v_next;
                res_reg[k]  <= res_next;
                rem_reg[k]  <= rem_next;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = res_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hw/rtl/tfpz_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
`timescale 1ns / 1ps

module tfpz_div_pipe #(
    parameter int NW    = 13,
    parameter int DW    = 29,
    parameter int QW    = tfpz_pkg::RATIO_BITS,
    parameter int SHIFT = tfpz_pkg::DIV_SHIFT,
    parameter int LANES = 2,
    parameter int SW    = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   in_num,
    input  logic [DW-1:0]              in_div,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   out_q,
    output logic [SW-1:0]              out_side
);

    localparam int AW = NW + SHIFT;
    localparam int TW = ((AW > DW + QW) ? AW : DW + QW) + 1;

    logic [LANES-1:0][AW-1:0] rem_reg  [QW];
    logic [LANES-1:0][QW-1:0] q_reg    [QW];
    logic [DW-1:0]            div_reg  [QW];
    logic [SW-1:0]            side_reg [QW];
    logic                     valid_reg[QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;

        logic [LANES-1:0][AW-1:0] rem_src, rem_next;
        logic [LANES-1:0][QW-1:0] q_src, q_next;
        logic [DW-1:0]            div_src;
        logic [SW-1:0]            side_src;
        logic                     valid_src;

        if (k == 0)
        begin : g_first
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_src[l] = AW'(in_num[l]) << SHIFT;
            end
            assign q_src     = '0;
            assign div_src   = in_div;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign rem_src   = rem_reg[k-1];
            assign q_src     = q_reg[k-1];
            assign div_src   = div_reg[k-1];
            assign side_src  = side_reg[k-1];
            assign valid_src = valid_reg[k-1];
        end

        // subtract the shifted divisor where it fits
        always_comb
        begin
            logic [TW-1:0] dsh;
            logic [TW-1:0] acc;
            dsh = TW'(div_src) << B;
            for (int l = 0; l < LANES; l++)
            begin
                acc       = TW'(rem_src[l]);
                q_next[l] = q_src[l];
                if (acc >= dsh)
                begin
                    rem_next[l]  = AW'(acc - dsh);
                    q_next[l][B] = 1'b1;
                end
                else
                begin
                    rem_next[l] = rem_src[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                div_reg[k]  <= div_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== hw/rtl/two_finger_pan_zoom_dead_zone_core.sv =====
// Top level of the two-finger pan and zoom core with a radial dead zone.
//
// Usage: one two-finger touch sample enters on the sample channel
// (sample_valid / sample_stall) and exactly one result leaves on the
// result channel (result_valid / result_stall). A beat moves when valid
// is high and stall is low. The dead-zone radius is written through the
// cfg channel (cfg_valid / cfg_ready, cfg_ready is always high); the user
// must do so only while no sample is in flight; the block does not check it.
// Throughput: one sample per clock when the result side does not stall.
// Pipeline: three front stages, COORD_BITS + 17 square root stages (one
// root bit each), one post stage, 18 divider stages (one ratio bit each),
// one multiply stage and the output register.
// While a result waits under stall the whole pipeline holds and
// sample_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits and loads the dead zone with 30 pixels.
// An inactive sample passes through the same pipeline and gives an all-zero result.
`timescale 1ns / 1ps

module two_finger_pan_zoom_dead_zone_core #(
    parameter int COORD_BITS = tfpz_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic                              active,
    input  logic [COORD_BITS-1:0]             start_a_x,
    input  logic [COORD_BITS-1:0]             start_a_y,
    input  logic [COORD_BITS-1:0]             start_b_x,
    input  logic [COORD_BITS-1:0]             start_b_y,
    input  logic [COORD_BITS-1:0]             now_a_x,
    input  logic [COORD_BITS-1:0]             now_a_y,
    input  logic [COORD_BITS-1:0]             now_b_x,
    input  logic [COORD_BITS-1:0]             now_b_y,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [COORD_BITS:0]               mid_start_x,
    output logic [COORD_BITS:0]               mid_start_y,
    output logic signed [COORD_BITS:0]        pan_x,
    output logic signed [COORD_BITS:0]        pan_y,
    output logic signed [COORD_BITS+1:0]      zoom_delta,
    output logic [COORD_BITS:0]               start_distance,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfpz_pkg::DZ_BITS-1:0]      cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int FB  = tfpz_pkg::FRAC_BITS;
    localparam int DZ  = tfpz_pkg::DZ_BITS;
    localparam int QW  = tfpz_pkg::RATIO_BITS;
    localparam int VW  = 2 * C + 2;
    localparam int RW  = VW / 2 + FB;
    localparam int TW  = DZ + QW;
    localparam int AWF = C + FB;
    localparam int CW  = ((AWF > TW) ? AWF : TW) + 1;
    localparam int SW1 = 2 + 2 * (C + 1) + 2 * (C + 2);
    localparam int SW2 = 5 + 4 * (C + 1) + (RW + 1) + (C + 1);

    // configuration register and its square
    logic [DZ-1:0]   dead_zone_reg;
    logic [2*DZ-1:0] dz_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dead_zone_reg <= tfpz_pkg::DEAD_ZONE_RESET;
        else if (cfg_valid)
            dead_zone_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        dz_sq_reg <= (2 * DZ)'(dead_zone_reg) * (2 * DZ)'(dead_zone_reg);
    end

    // global advance: hold everything while a result waits under stall
    logic en;
    logic result_valid_reg;

    assign en           = !(result_valid_reg && result_stall);
    assign sample_stall = !en;

    // front stages
    logic                f_valid, f_pan_on, f_act;
    logic [VW-1:0]       f_l2, f_d1, f_d2;
    logic [C:0]          f_mid_x, f_mid_y;
    logic signed [C+1:0] f_dhx, f_dhy;

    tfpz_front #(
        .C (C),
        .VW(VW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (sample_valid),
        .active      (active),
        .start_a_x   (start_a_x),
        .start_a_y   (start_a_y),
        .start_b_x   (start_b_x),
        .start_b_y   (start_b_y),
        .now_a_x     (now_a_x),
        .now_a_y     (now_a_y),
        .now_b_x     (now_b_x),
        .now_b_y     (now_b_y),
        .dead_zone_sq(dz_sq_reg),
        .out_valid   (f_valid),
        .l2          (f_l2),
        .d1          (f_d1),
        .d2          (f_d2),
        .mid_x       (f_mid_x),
        .mid_y       (f_mid_y),
        .dhx         (f_dhx),
        .dhy         (f_dhy),
        .pan_on      (f_pan_on),
        .act         (f_act)
    );

    // square roots: lane 0 pan length, lane 1 start distance, lane 2 now distance
    logic                   s_valid, s_act, s_pan_on;
    logic [2:0][RW-1:0]     s_root;
    logic [SW1-1:0]         s_side;
    logic [C:0]             s_mid_x, s_mid_y;
    logic signed [C+1:0]    s_dhx, s_dhy;

    tfpz_sqrt_pipe #(
        .VW   (VW),
        .FRAC (FB),
        .LANES(3),
        .SW   (SW1),
        .RW   (RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_v     ({f_d2, f_d1, f_l2}),
        .in_side  ({f_act, f_pan_on, f_mid_x, f_mid_y, f_dhx, f_dhy}),
        .out_valid(s_valid),
        .out_root (s_root),
        .out_side (s_side)
    );

    assign {s_act, s_pan_on, s_mid_x, s_mid_y, s_dhx, s_dhy} = s_side;

    // post stage: magnitudes, distance difference, zero-length flag
    logic signed [C+1:0] s_absx, s_absy;
    logic                p_valid_reg, p_act_reg, p_pan_on_reg, p_len_zero_reg;
    logic                p_negx_reg, p_negy_reg;
    logic [C:0]          p_magx_reg, p_magy_reg, p_mid_x_reg, p_mid_y_reg, p_dist_reg;
    logic [RW-1:0]       p_len_reg;
    logic signed [RW:0]  p_diff_reg;

    assign s_absx = s_dhx[C+1] ? -s_dhx : s_dhx;
    assign s_absy = s_dhy[C+1] ? -s_dhy : s_dhy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_act_reg      <= s_act;
            p_pan_on_reg   <= s_pan_on;
            p_len_zero_reg <= (s_root[0] == '0);
            p_len_reg      <= s_root[0];
            p_negx_reg     <= s_dhx[C+1];
            p_negy_reg     <= s_dhy[C+1];
            p_magx_reg     <= s_absx[C:0];
            p_magy_reg     <= s_absy[C:0];
            p_mid_x_reg    <= s_mid_x;
            p_mid_y_reg    <= s_mid_y;
            p_diff_reg     <= $signed({1'b0, s_root[1]}) - $signed({1'b0, s_root[2]});
            p_dist_reg     <= s_root[1][RW-1:FB];
        end
    end

    // ratio = magnitude * 2^31 / length, both axes against one length
    logic                d_valid, d_act, d_pan_on, d_len_zero, d_negx, d_negy;
    logic [1:0][QW-1:0]  d_q;
    logic [SW2-1:0]      d_side;
    logic [C:0]          d_magx, d_magy, d_mid_x, d_mid_y, d_dist;
    logic signed [RW:0]  d_diff;

    tfpz_div_pipe #(
        .NW   (C + 1),
        .DW   (RW),
        .QW   (QW),
        .SHIFT(tfpz_pkg::DIV_SHIFT),
        .LANES(2),
        .SW   (SW2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (p_valid_reg),
        .in_num   ({p_magy_reg, p_magx_reg}),
        .in_div   (p_len_reg),
        .in_side  ({p_act_reg, p_pan_on_reg, p_len_zero_reg, p_negx_reg, p_negy_reg,
                    p_magx_reg, p_magy_reg, p_mid_x_reg, p_mid_y_reg, p_diff_reg,
                    p_dist_reg}),
        .out_valid(d_valid),
        .out_q    (d_q),
        .out_side (d_side)
    );

    assign {d_act, d_pan_on, d_len_zero, d_negx, d_negy, d_magx, d_magy,
            d_mid_x, d_mid_y, d_diff, d_dist} = d_side;

    // multiply stage: thresholds and the zoom dead zone
    logic signed [RW:0]  d_absdiff;
    logic [C:0]          d_zmag, d_zsub;
    logic [C:0]          d_dz_ext;
    logic signed [C+1:0] zoom_next;

    assign d_absdiff = d_diff[RW] ? -d_diff : d_diff;
    assign d_zmag    = d_absdiff[RW-1:FB];
    assign d_dz_ext  = (C + 1)'(dead_zone_reg);
    assign d_zsub    = d_zmag - d_dz_ext;

    always_comb
    begin
        if (d_zmag < d_dz_ext)
            zoom_next = '0;
        else if (d_diff[RW])
            zoom_next = -$signed({1'b0, d_zsub});
        else
            zoom_next = $signed({1'b0, d_zsub});
    end

    logic                m_valid_reg, m_act_reg, m_pan_on_reg, m_negx_reg, m_negy_reg;
    logic [TW-1:0]       m_thrx_reg, m_thry_reg;
    logic [C-1:0]        m_smagx_reg, m_smagy_reg;
    logic [C:0]          m_mid_x_reg, m_mid_y_reg, m_dist_reg;
    logic signed [C+1:0] m_zoom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_act_reg    <= d_act;
            m_pan_on_reg <= d_pan_on;
            m_negx_reg   <= d_negx;
            m_negy_reg   <= d_negy;
            m_thrx_reg   <= d_len_zero ? '0 : TW'(dead_zone_reg) * TW'(d_q[0]);
            m_thry_reg   <= d_len_zero ? '0 : TW'(dead_zone_reg) * TW'(d_q[1]);
            m_smagx_reg  <= d_magx[C:1];
            m_smagy_reg  <= d_magy[C:1];
            m_mid_x_reg  <= d_mid_x;
            m_mid_y_reg  <= d_mid_y;
            m_dist_reg   <= d_dist;
            m_zoom_reg   <= zoom_next;
        end
    end

    // final stage: shrink each half shift by its threshold
    logic [CW-1:0]     ax, ay, subx, suby;
    logic [C-1:0]      mx, my;
    logic signed [C:0] pan_x_next, pan_y_next;

    assign ax   = CW'({m_smagx_reg, {FB{1'b0}}});
    assign ay   = CW'({m_smagy_reg, {FB{1'b0}}});
    assign subx = ax - CW'(m_thrx_reg);
    assign suby = ay - CW'(m_thry_reg);
    assign mx   = (ax < CW'(m_thrx_reg)) ? '0 : subx[AWF-1:FB];
    assign my   = (ay < CW'(m_thry_reg)) ? '0 : suby[AWF-1:FB];

    always_comb
    begin
        pan_x_next = '0;
        pan_y_next = '0;
        if (m_pan_on_reg)
        begin
            pan_x_next = m_negx_reg ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
            pan_y_next = m_negy_reg ? -$signed({1'b0, my}) : $signed({1'b0, my});
        end
    end

    logic [C:0]          mid_x_reg, mid_y_reg, dist_reg;
    logic signed [C:0]   pan_x_reg, pan_y_reg;
    logic signed [C+1:0] zoom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= m_valid_reg;
    end

    // drop everything to zero for an inactive sample
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_x_reg <= m_act_reg ? m_mid_x_reg : '0;
            mid_y_reg <= m_act_reg ? m_mid_y_reg : '0;
            pan_x_reg <= m_act_reg ? pan_x_next : '0;
            pan_y_reg <= m_act_reg ? pan_y_next : '0;
            zoom_reg  <= m_act_reg ? m_zoom_reg : '0;
            dist_reg  <= m_act_reg ? m_dist_reg : '0;
        end
    end

    assign result_valid   = result_valid_reg;
    assign mid_start_x    = mid_x_reg;
    assign mid_start_y    = mid_y_reg;
    assign pan_x          = pan_x_reg;
    assign pan_y          = pan_y_reg;
    assign zoom_delta     = zoom_reg;
    assign start_distance = dist_reg;

endmodule

// ===== hw/rtl/tfpz_checker.sv =====
// Port-level checker for the pan and zoom core, bound to the top level.
`timescale 1ns / 1ps

module tfpz_checker #(
    parameter int COORD_BITS = tfpz_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         sample_stall,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [COORD_BITS:0]          mid_start_x,
    input logic [COORD_BITS:0]          mid_start_y,
    input logic signed [COORD_BITS:0]   pan_x,
    input logic signed [COORD_BITS:0]   pan_y,
    input logic signed [COORD_BITS+1:0] zoom_delta,
    input logic [COORD_BITS:0]          start_distance
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid
            && $stable(mid_start_x) && $stable(mid_start_y) && $stable(pan_x)
            && $stable(pan_y) && $stable(zoom_delta) && $stable(start_distance))
        else $error("stalled result changed");

    // back-pressure reaches the sample side
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> sample_stall)
        else $error("sample taken while result stalled");

    // zoom in never exceeds the start distance
    a_zoom_le: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (zoom_delta <= $signed({1'b0, start_distance})))
        else $error("zoom above start distance");

    // fingers starting together cannot zoom in
    a_zoom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (start_distance == '0) |-> (zoom_delta <= 0))
        else $error("positive zoom from zero start distance");

endmodule

bind two_finger_pan_zoom_dead_zone_core tfpz_checker #(
    .COORD_BITS(COORD_BITS)
) u_tfpz_checker (.*);
